### hw/rtl/aee_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// aee_pkg: shared types and constants of the animation easing evaluator
// Field widths, easing kind codes, register indexes and the sideband record
// that travels with every sample down the pipeline.
// ----------------------------------------------------------------------------
package aee_pkg;

    localparam int TIME_W    = 48;  // elapsed, active and leg index
    localparam int DELTA_W   = 32;
    localparam int VALUE_W   = 32;  // Q16.16 values
    localparam int DUR_W     = 32;  // delay and duration
    localparam int LEGS_W    = 16;
    localparam int CTRL_W    = 16;  // one bezier control, Q3.12
    localparam int CTRL_FRAC = 12;
    localparam int CFG_W     = 64;
    localparam int CFG_IDX_W = 3;
    localparam int KIND_W    = 3;

    typedef enum logic [KIND_W-1:0] {
        KIND_LINEAR   = 3'd0,
        KIND_QUAD_IN  = 3'd1,
        KIND_QUAD_OUT = 3'd2,
        KIND_SMOOTH   = 3'd3,
        KIND_BEZIER   = 3'd4
    } t_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DELAY    = 3'd0,
        REG_DURATION = 3'd1,
        REG_LEGS     = 3'd2,
        REG_KIND     = 3'd3,
        REG_REVERSE  = 3'd4,
        REG_FROM     = 3'd5,
        REG_TO       = 3'd6,
        REG_CONTROLS = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic                       valid;
        logic                       early;    // sample lies inside the delay
        logic [TIME_W-1:0]          active;
        logic signed [DELTA_W-1:0]  delta;
    } t_side;

endpackage
`default_nettype wire

### hw/rtl/aee_div_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// aee_div_cell: one restoring division step
// Shifts one dividend bit into the partial remainder and one quotient bit
// into the low end of the shift word.
// ----------------------------------------------------------------------------
module aee_div_cell #(
    parameter int QW = 64
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_en,
    input  wire aee_pkg::t_side               i_side,
    input  wire logic [QW-1:0]                i_q,
    input  wire logic [aee_pkg::DUR_W-1:0]    i_rem,
    input  wire logic [aee_pkg::DUR_W-1:0]    i_div,
    output aee_pkg::t_side                    o_side,
    output logic [QW-1:0]                     o_q,
    output logic [aee_pkg::DUR_W-1:0]         o_rem
);

    aee_pkg::t_side              r_side;
    logic [QW-1:0]               r_q;
    logic [aee_pkg::DUR_W-1:0]   r_rem;

    logic [aee_pkg::DUR_W:0]     w_trial;
    logic [aee_pkg::DUR_W:0]     w_diff;
    logic                        w_fit;
    logic [aee_pkg::DUR_W-1:0]   n_rem;
    logic [QW-1:0]               n_q;

    assign w_trial = {i_rem, i_q[QW-1]};
    assign w_fit   = w_trial >= {1'b0, i_div};
    assign w_diff  = w_trial - {1'b0, i_div};
    assign n_rem   = w_fit ? w_diff[aee_pkg::DUR_W-1:0] : w_trial[aee_pkg::DUR_W-1:0];
    assign n_q     = {i_q[QW-2:0], w_fit};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side.valid <= 1'b0;
        end else if (i_en) begin
            r_side <= i_side;
            r_q    <= n_q;
            r_rem  <= n_rem;
        end
    end

    assign o_side = r_side;
    assign o_q    = r_q;
    assign o_rem  = r_rem;

endmodule
`default_nettype wire

### hw/rtl/aee_bez_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// aee_bez_cell: one bisection step of the bezier solve
// Settles the previous step's compare, takes the midpoint and evaluates the
// curve at it over three register stages.
// ----------------------------------------------------------------------------
module aee_bez_cell #(
    parameter int FB = 16
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_en,
    input  wire aee_pkg::t_side                        i_side,
    input  wire logic [aee_pkg::TIME_W-1:0]            i_leg,
    input  wire logic [FB-1:0]                         i_f,
    input  wire logic [FB:0]                           i_lo,
    input  wire logic [FB:0]                           i_hi,
    input  wire logic [FB:0]                           i_mid,
    input  wire logic signed [FB+5:0]                  i_v,
    input  wire logic signed [aee_pkg::CTRL_W-1:0]     i_p1,
    input  wire logic signed [aee_pkg::CTRL_W-1:0]     i_p2,
    output aee_pkg::t_side                             o_side,
    output logic [aee_pkg::TIME_W-1:0]                 o_leg,
    output logic [FB-1:0]                              o_f,
    output logic [FB:0]                                o_lo,
    output logic [FB:0]                                o_hi,
    output logic [FB:0]                                o_mid,
    output logic signed [FB+5:0]                       o_v
);

    localparam int EW = FB + 6;
    localparam int PW = aee_pkg::CTRL_W + FB + 4;
    localparam logic [FB:0] ONE = {1'b1, {FB{1'b0}}};

    // payload delayed alongside the arithmetic
    aee_pkg::t_side              r_side [3];
    logic [aee_pkg::TIME_W-1:0]  r_leg  [3];
    logic [FB-1:0]               r_f    [3];
    logic [FB:0]                 r_lo   [3];
    logic [FB:0]                 r_hi   [3];
    logic [FB:0]                 r_t    [3];

    logic [FB:0]                 r_s1, r_ts1, r_tt1;
    logic [FB+2:0]               r_b1, r_b2;
    logic [FB:0]                 r_b3;
    logic signed [EW-1:0]        r_v;

    // settle previous step
    logic                        w_below;
    logic [FB:0]                 n_lo, n_hi, n_t, n_s;
    logic [FB+1:0]               w_sum;
    logic [2*FB+1:0]             w_tsf, w_ttf;

    assign w_below = i_v < $signed({{(EW-FB){1'b0}}, i_f});
    assign n_lo    = w_below ? i_mid : i_lo;
    assign n_hi    = w_below ? i_hi  : i_mid;
    assign w_sum   = {1'b0, n_lo} + {1'b0, n_hi};
    assign n_t     = w_sum[FB+1:1];
    assign n_s     = ONE - n_t;
    assign w_tsf   = (2*FB+2)'(n_t) * (2*FB+2)'(n_s);
    assign w_ttf   = (2*FB+2)'(n_t) * (2*FB+2)'(n_t);

    // stage two: basis weights
    logic [2*FB+1:0]             w_tssf, w_tstf, w_tttf;
    logic [FB:0]                 w_tss, w_tst;
    logic [FB+2:0]               n_b1, n_b2;

    assign w_tssf = (2*FB+2)'(r_ts1) * (2*FB+2)'(r_s1);
    assign w_tstf = (2*FB+2)'(r_ts1) * (2*FB+2)'(r_t[0]);
    assign w_tttf = (2*FB+2)'(r_tt1) * (2*FB+2)'(r_t[0]);
    assign w_tss  = w_tssf[2*FB:FB];
    assign w_tst  = w_tstf[2*FB:FB];
    assign n_b1   = {2'b00, w_tss} + {1'b0, w_tss, 1'b0};
    assign n_b2   = {2'b00, w_tst} + {1'b0, w_tst, 1'b0};

    // stage three: weighted controls
    logic signed [PW-1:0]        w_m1, w_m2;
    logic signed [PW:0]          w_msum, w_msh;
    logic signed [EW-1:0]        n_v;

    assign w_m1   = i_p1 * $signed({1'b0, r_b1});
    assign w_m2   = i_p2 * $signed({1'b0, r_b2});
    assign w_msum = {w_m1[PW-1], w_m1} + {w_m2[PW-1], w_m2};
    assign w_msh  = w_msum >>> aee_pkg::CTRL_FRAC;
    assign n_v    = w_msh[EW-1:0] + $signed({{(EW-FB-1){1'b0}}, r_b3});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 3; k++) begin
                r_side[k].valid <= 1'b0;
            end
        end else if (i_en) begin
            r_side[0] <= i_side;
            r_leg[0]  <= i_leg;
            r_f[0]    <= i_f;
            r_lo[0]   <= n_lo;
            r_hi[0]   <= n_hi;
            r_t[0]    <= n_t;
            r_s1      <= n_s;
            r_ts1     <= w_tsf[2*FB:FB];
            r_tt1     <= w_ttf[2*FB:FB];
            for (int k = 1; k < 3; k++) begin
                r_side[k] <= r_side[k-1];
                r_leg[k]  <= r_leg[k-1];
                r_f[k]    <= r_f[k-1];
                r_lo[k]   <= r_lo[k-1];
                r_hi[k]   <= r_hi[k-1];
                r_t[k]    <= r_t[k-1];
            end
            r_b1 <= n_b1;
            r_b2 <= n_b2;
            r_b3 <= w_tttf[2*FB:FB];
            r_v  <= n_v;
        end
    end

    assign o_side = r_side[2];
    assign o_leg  = r_leg[2];
    assign o_f    = r_f[2];
    assign o_lo   = r_lo[2];
    assign o_hi   = r_hi[2];
    assign o_mid  = r_t[2];
    assign o_v    = r_v;

endmodule
`default_nettype wire

### hw/rtl/aee_ease.sv
`default_nettype none
// ----------------------------------------------------------------------------
// aee_ease: easing curve and leg reversal
// Two stages: a square, then the kind select with smoothstep's second
// product, then reversal of odd legs when reversal is enabled.
// ----------------------------------------------------------------------------
module aee_ease #(
    parameter int FB = 16
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_en,
    input  wire aee_pkg::t_side                 i_side,
    input  wire logic [aee_pkg::TIME_W-1:0]     i_leg,
    input  wire logic [FB-1:0]                  i_f,
    input  wire logic signed [FB+5:0]           i_v,
    input  wire logic [aee_pkg::KIND_W-1:0]     i_kind,
    input  wire logic                           i_revp,
    output aee_pkg::t_side                      o_side,
    output logic [aee_pkg::TIME_W-1:0]          o_leg,
    output logic signed [FB+6:0]                o_frac
);

    localparam int EW = FB + 6;
    localparam logic [FB:0]   ONE       = {1'b1, {FB{1'b0}}};
    localparam logic [FB+1:0] THREE_ONE = {2'b11, {FB{1'b0}}};

    aee_pkg::t_side              r_side1, r_side2;
    logic [aee_pkg::TIME_W-1:0]  r_leg1, r_leg2;
    logic [FB-1:0]               r_f1;
    logic signed [EW-1:0]        r_v1;
    logic [FB:0]                 r_sq1;
    logic signed [EW:0]          r_frac2;

    logic [FB:0]                 w_a;
    logic [2*FB+1:0]             w_sqf;

    assign w_a   = (i_kind == aee_pkg::KIND_QUAD_OUT) ? ONE - {1'b0, i_f} : {1'b0, i_f};
    assign w_sqf = (2*FB+2)'(w_a) * (2*FB+2)'(w_a);

    logic [FB+1:0]               w_k;
    logic [2*FB+2:0]             w_mf;
    logic signed [EW-1:0]        w_e;
    logic                        w_rev;
    logic signed [EW:0]          n_frac;

    assign w_k  = THREE_ONE - {1'b0, r_f1, 1'b0};
    assign w_mf = (2*FB+3)'(r_sq1) * (2*FB+3)'(w_k);

    always_comb begin
        w_e = $signed(EW'(r_f1));
        if (r_f1 == '0) begin
            w_e = '0;
        end else begin
            case (i_kind)
                aee_pkg::KIND_QUAD_IN:  w_e = $signed(EW'(r_sq1));
                aee_pkg::KIND_QUAD_OUT: w_e = $signed(EW'(ONE - r_sq1));
                aee_pkg::KIND_SMOOTH:   w_e = $signed(EW'(w_mf[2*FB+2:FB]));
                aee_pkg::KIND_BEZIER:   w_e = r_v1;
                default:                w_e = $signed(EW'(r_f1));
            endcase
        end
    end

    assign w_rev  = i_revp & r_leg1[0];
    assign n_frac = w_rev ? $signed((EW+1)'(ONE)) - {w_e[EW-1], w_e} : {w_e[EW-1], w_e};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side1.valid <= 1'b0;
            r_side2.valid <= 1'b0;
        end else if (i_en) begin
            r_side1 <= i_side;
            r_leg1  <= i_leg;
            r_f1    <= i_f;
            r_v1    <= i_v;
            r_sq1   <= w_sqf[2*FB:FB];
            r_side2 <= r_side1;
            r_leg2  <= r_leg1;
            r_frac2 <= n_frac;
        end
    end

    assign o_side = r_side2;
    assign o_leg  = r_leg2;
    assign o_frac = r_frac2;

endmodule
`default_nettype wire

### hw/rtl/animation_easing_evaluator.sv
`default_nettype none
// Throughput: one sample per cycle while the chain is not stalled; every stage is a register of the cell chain.
// The chain stalls only while a result waits at the output and the stage before
//   it is occupied; a bubble there still lets the chain advance.
// Reset (synchronous, active low) clears all configuration registers to zero and
//   every stage's valid flag; there is no clearing pass.
// ----------------------------------------------------------------------------
// animation_easing_evaluator: eased animation value from elapsed time
// Removes the start delay, splits active time into legs with a bit-serial
// divider chain, eases the leg progress (optionally through a bisected cubic
// bezier) and interpolates between the from and to values.
// ----------------------------------------------------------------------------
module animation_easing_evaluator #(
    parameter int BISECT_STEPS  = 16,
    parameter int FRACTION_BITS = 16
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    // configuration write port
    input  wire logic                                   i_cfg_we,
    input  wire logic [aee_pkg::CFG_IDX_W-1:0]          i_cfg_index,
    input  wire logic [aee_pkg::CFG_W-1:0]              i_cfg_data,
    // sample input
    input  wire logic                                   i_in_valid,
    output logic                                        o_in_ready,
    input  wire logic [aee_pkg::TIME_W-1:0]             i_elapsed_us,
    input  wire logic signed [aee_pkg::DELTA_W-1:0]     i_delta_us,
    // result output
    output logic                                        o_out_valid,
    input  wire logic                                   i_out_ready,
    output logic [aee_pkg::TIME_W-1:0]                  o_active_time,
    output logic [aee_pkg::TIME_W-1:0]                  o_leg_index,
    output logic [FRACTION_BITS:0]                      o_fraction_out,
    output logic signed [aee_pkg::VALUE_W-1:0]          o_value_out,
    output logic                                        o_reversed,
    output logic                                        o_terminal,
    output logic signed [aee_pkg::DELTA_W-1:0]          o_delta_out
);

    localparam int FB  = FRACTION_BITS;
    localparam int TW  = aee_pkg::TIME_W;
    localparam int VW  = aee_pkg::VALUE_W;
    localparam int CW  = aee_pkg::CTRL_W;
    localparam int QW  = TW + FB;              // divider shift word
    localparam int EW  = FB + 6;               // eased value, signed
    localparam int NB  = BISECT_STEPS + 1;     // bisection cells plus final y eval
    localparam int PRW = VW + 1 + EW + 1;      // interpolation product
    localparam logic [FB:0] ONE = {1'b1, {FB{1'b0}}};

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [aee_pkg::DUR_W-1:0]      r_delay;
    logic [aee_pkg::DUR_W-1:0]      r_duration;
    logic [aee_pkg::LEGS_W-1:0]     r_legs;
    logic [aee_pkg::KIND_W-1:0]     r_kind;
    logic                           r_reverse;
    logic signed [VW-1:0]           r_from;
    logic signed [VW-1:0]           r_to;
    logic [aee_pkg::CFG_W-1:0]      r_ctrl;
    logic [TW-1:0]                  r_prod;    // duration * legs, the end of motion

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay    <= '0;
            r_duration <= '0;
            r_legs     <= '0;
            r_kind     <= '0;
            r_reverse  <= 1'b0;
            r_from     <= '0;
            r_to       <= '0;
            r_ctrl     <= '0;
        end else if (i_cfg_we) begin
            case (aee_pkg::t_reg_idx'(i_cfg_index))
                aee_pkg::REG_DELAY:    r_delay    <= i_cfg_data[aee_pkg::DUR_W-1:0];
                aee_pkg::REG_DURATION: r_duration <= i_cfg_data[aee_pkg::DUR_W-1:0];
                aee_pkg::REG_LEGS:     r_legs     <= i_cfg_data[aee_pkg::LEGS_W-1:0];
                aee_pkg::REG_KIND:     r_kind     <= i_cfg_data[aee_pkg::KIND_W-1:0];
                aee_pkg::REG_REVERSE:  r_reverse  <= i_cfg_data[0];
                aee_pkg::REG_FROM:     r_from     <= $signed(i_cfg_data[VW-1:0]);
                aee_pkg::REG_TO:       r_to       <= $signed(i_cfg_data[VW-1:0]);
                aee_pkg::REG_CONTROLS: r_ctrl     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Only read far down the chain, so the settling of this register is never seen.
    always_ff @(posedge i_clk) begin
        r_prod <= TW'(r_duration) * TW'(r_legs);
    end

    logic signed [CW-1:0] w_x1, w_y1, w_x2, w_y2;
    assign w_x1 = $signed(r_ctrl[CW-1:0]);
    assign w_y1 = $signed(r_ctrl[2*CW-1:CW]);
    assign w_x2 = $signed(r_ctrl[3*CW-1:2*CW]);
    assign w_y2 = $signed(r_ctrl[4*CW-1:3*CW]);

    // ------------------------------------------------------------------
    // Flow control: the whole chain advances together. It holds only when
    // the output register is full, not being taken, and the stage feeding
    // it has an item.
    // ------------------------------------------------------------------
    logic                 w_en;
    logic                 w_out_load;
    aee_pkg::t_side       r_i1_side;

    assign w_out_load = !o_out_valid || i_out_ready;
    assign w_en       = w_out_load || !r_i1_side.valid;
    assign o_in_ready = w_en;

    // ------------------------------------------------------------------
    // Front stage: strip the delay
    // ------------------------------------------------------------------
    aee_pkg::t_side       r_front;
    aee_pkg::t_side       n_front;
    logic                 w_before;

    assign w_before = i_elapsed_us < TW'(r_delay);

    always_comb begin
        n_front.valid  = i_in_valid;
        n_front.early  = w_before;
        n_front.active = w_before ? '0 : i_elapsed_us - TW'(r_delay);
        n_front.delta  = i_delta_us;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front.valid <= 1'b0;
        end else if (w_en) begin
            r_front <= n_front;
        end
    end

    // ------------------------------------------------------------------
    // Divider chain: one quotient bit per cell. The top TW quotient bits are
    // the leg index, the low FB bits the raw progress within the leg.
    // ------------------------------------------------------------------
    aee_pkg::t_side              w_dside [QW+1];
    logic [QW-1:0]               w_dq    [QW+1];
    logic [aee_pkg::DUR_W-1:0]   w_drem  [QW+1];

    assign w_dside[0] = r_front;
    assign w_dq[0]    = {r_front.active, {FB{1'b0}}};
    assign w_drem[0]  = '0;

    for (genvar k = 0; k < QW; k++) begin : g_div
        aee_div_cell #(
            .QW (QW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_side  (w_dside[k]),
            .i_q     (w_dq[k]),
            .i_rem   (w_drem[k]),
            .i_div   (r_duration),
            .o_side  (w_dside[k+1]),
            .o_q     (w_dq[k+1]),
            .o_rem   (w_drem[k+1])
        );
    end

    // ------------------------------------------------------------------
    // Bezier chain: BISECT_STEPS cells solve x(t) = raw, the last cell
    // evaluates y at the solved t. Other kinds ride along unchanged.
    // The seed (mid 0, curve value -1) makes the first cell keep [0, ONE].
    // ------------------------------------------------------------------
    aee_pkg::t_side              w_bside [NB+1];
    logic [TW-1:0]               w_bleg  [NB+1];
    logic [FB-1:0]               w_bf    [NB+1];
    logic [FB:0]                 w_blo   [NB+1];
    logic [FB:0]                 w_bhi   [NB+1];
    logic [FB:0]                 w_bmid  [NB+1];
    logic signed [EW-1:0]        w_bv    [NB+1];

    assign w_bside[0] = w_dside[QW];
    assign w_bleg[0]  = w_dq[QW][QW-1:FB];
    assign w_bf[0]    = w_dq[QW][FB-1:0];
    assign w_blo[0]   = '0;
    assign w_bhi[0]   = ONE;
    assign w_bmid[0]  = '0;
    assign w_bv[0]    = '1;

    for (genvar k = 0; k < NB; k++) begin : g_bez
        logic signed [CW-1:0] w_p1, w_p2;
        assign w_p1 = (k < BISECT_STEPS) ? w_x1 : w_y1;
        assign w_p2 = (k < BISECT_STEPS) ? w_x2 : w_y2;

        aee_bez_cell #(
            .FB (FB)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_side  (w_bside[k]),
            .i_leg   (w_bleg[k]),
            .i_f     (w_bf[k]),
            .i_lo    (w_blo[k]),
            .i_hi    (w_bhi[k]),
            .i_mid   (w_bmid[k]),
            .i_v     (w_bv[k]),
            .i_p1    (w_p1),
            .i_p2    (w_p2),
            .o_side  (w_bside[k+1]),
            .o_leg   (w_bleg[k+1]),
            .o_f     (w_bf[k+1]),
            .o_lo    (w_blo[k+1]),
            .o_hi    (w_bhi[k+1]),
            .o_mid   (w_bmid[k+1]),
            .o_v     (w_bv[k+1])
        );
    end

    // ------------------------------------------------------------------
    // Easing and reversal
    // ------------------------------------------------------------------
    aee_pkg::t_side              w_eside;
    logic [TW-1:0]               w_eleg;
    logic signed [EW:0]          w_efrac;

    aee_ease #(
        .FB (FB)
    ) u_ease (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_side  (w_bside[NB]),
        .i_leg   (w_bleg[NB]),
        .i_f     (w_bf[NB]),
        .i_v     (w_bv[NB]),
        .i_kind  (r_kind),
        .i_revp  (r_reverse),
        .o_side  (w_eside),
        .o_leg   (w_eleg),
        .o_frac  (w_efrac)
    );

    // ------------------------------------------------------------------
    // Interpolation product: (to - from) * frac
    // ------------------------------------------------------------------
    logic [TW-1:0]               r_i1_leg;
    logic signed [EW:0]          r_i1_frac;
    logic signed [PRW-1:0]       r_i1_prod;
    logic signed [VW:0]          w_span;

    assign w_span = {r_to[VW-1], r_to} - {r_from[VW-1], r_from};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_i1_side.valid <= 1'b0;
        end else if (w_en) begin
            r_i1_side <= w_eside;
            r_i1_leg  <= w_eleg;
            r_i1_frac <= w_efrac;
            r_i1_prod <= w_span * w_efrac;
        end
    end

    // ------------------------------------------------------------------
    // Result select: before the delay, past the last leg, zero duration,
    // or a moving sample. Value and fraction are saturated here.
    // ------------------------------------------------------------------
    logic signed [PRW-1:0]       w_q;
    logic signed [PRW:0]         w_vsum;
    logic [PRW-VW+1:0]           w_vtop;
    logic signed [VW-1:0]        w_vsat;
    logic [FB:0]                 w_fsat;
    logic                        w_end;
    logic [TW-1:0]               w_last_leg;
    logic                        w_last_rev;
    logic                        w_mov_rev;

    logic [TW-1:0]               n_leg;
    logic [FB:0]                 n_frac;
    logic signed [VW-1:0]        n_value;
    logic                        n_rev;
    logic                        n_term;

    assign w_q    = r_i1_prod >>> FB;
    assign w_vsum = {w_q[PRW-1], w_q} + (PRW+1)'(r_from);
    assign w_vtop = w_vsum[PRW:VW-1];

    always_comb begin
        if ((w_vtop == '0) || (w_vtop == '1)) begin
            w_vsat = w_vsum[VW-1:0];
        end else if (w_vsum[PRW]) begin
            w_vsat = {1'b1, {(VW-1){1'b0}}};
        end else begin
            w_vsat = {1'b0, {(VW-1){1'b1}}};
        end
    end

    always_comb begin
        if (r_i1_frac[EW]) begin
            w_fsat = '0;
        end else if (r_i1_frac > $signed((EW+1)'(ONE))) begin
            w_fsat = ONE;
        end else begin
            w_fsat = r_i1_frac[FB:0];
        end
    end

    assign w_end      = (r_legs != '0) && (r_i1_side.active >= r_prod);
    assign w_last_leg = TW'(r_legs) - TW'(1);
    assign w_last_rev = r_reverse & w_last_leg[0];
    assign w_mov_rev  = r_reverse & r_i1_leg[0];

    always_comb begin
        n_leg   = r_i1_leg;
        n_frac  = w_fsat;
        n_value = w_vsat;
        n_rev   = w_mov_rev;
        n_term  = 1'b0;
        if (r_i1_side.early) begin
            n_leg   = '0;
            n_frac  = '0;
            n_value = r_from;
            n_rev   = 1'b0;
        end else if (w_end) begin
            n_leg   = w_last_leg;
            n_rev   = w_last_rev;
            n_frac  = w_last_rev ? '0 : ONE;
            n_value = w_last_rev ? r_from : r_to;
            n_term  = 1'b1;
        end else if (r_duration == '0) begin
            n_leg   = '0;
            n_frac  = ONE;
            n_value = r_to;
            n_rev   = 1'b0;
            n_term  = 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (w_out_load) begin
            o_out_valid <= r_i1_side.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            o_active_time  <= r_i1_side.active;
            o_leg_index    <= n_leg;
            o_fraction_out <= n_frac;
            o_value_out    <= n_value;
            o_reversed     <= n_rev;
            o_terminal     <= n_term;
            o_delta_out    <= r_i1_side.delta;
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (o_out_valid && !i_out_ready))
        else $error("input stalled without a waiting result");

    a_fraction_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_fraction_out <= ONE))
        else $error("fraction beyond one");

    a_term_rev_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_terminal && o_reversed) |-> (o_fraction_out == '0))
        else $error("reversed terminal result with nonzero fraction");

    a_term_fwd_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_terminal && !o_reversed) |-> (o_fraction_out == ONE))
        else $error("forward terminal result not at one");

endmodule
`default_nettype wire

### tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for animation_easing_evaluator
// Writes sets of timing, easing and value registers, streams elapsed-time
// samples through the valid/ready input and compares every result transfer,
// field by field, with a bit-exact predictor of the easing pipeline.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint ONE         = 64'sd65536;
    localparam longint CYCLE_LIMIT = 3000000;
    localparam int     PIPE_DRAIN  = 140;    // longer than the pipeline latency

    // one expected result transfer
    typedef struct {
        logic [47:0]        active;
        logic [47:0]        leg;
        logic [16:0]        frac;
        logic signed [31:0] value;
        logic               rev;
        logic               term;
        logic signed [31:0] delta;
    } t_sample_res;

    // ------------------------------------------------------------------------
    // Scoreboard: mirror of the registers plus the queue of pending results
    // ------------------------------------------------------------------------
    class easing_scoreboard;
        longint unsigned delay, dur, legs, kind, rev_mode, controls;
        longint          from_v, to_v;
        t_sample_res     pending_q[$];
        int              errors;
        int              n_checked;

        function new();
            delay = 0; dur = 0; legs = 0; kind = 0; rev_mode = 0; controls = 0;
            from_v = 0; to_v = 0; errors = 0; n_checked = 0;
        endfunction

        function void set_reg(aee_pkg::t_reg_idx idx, logic [63:0] d);
            case (idx)
                aee_pkg::REG_DELAY:    delay    = 64'(d[31:0]);
                aee_pkg::REG_DURATION: dur      = 64'(d[31:0]);
                aee_pkg::REG_LEGS:     legs     = 64'(d[15:0]);
                aee_pkg::REG_KIND:     kind     = 64'(d[2:0]);
                aee_pkg::REG_REVERSE:  rev_mode = 64'(d[0]);
                aee_pkg::REG_FROM:     from_v   = longint'($signed(d[31:0]));
                aee_pkg::REG_TO:       to_v     = longint'($signed(d[31:0]));
                aee_pkg::REG_CONTROLS: controls = d;
                default: ;
            endcase
        endfunction

        // floor shifts; >>> on a signed longint is already a floor
        function longint shr16(longint v);
            return v >>> 16;
        endfunction

        function longint curve(longint p1, longint p2, longint t);
            longint s, ts, b1, b2, b3;
            s  = ONE - t;
            ts = shr16(t * s);
            b1 = 3 * shr16(ts * s);
            b2 = 3 * shr16(ts * t);
            b3 = shr16(shr16(t * t) * t);
            return ((p1 * b1 + p2 * b2) >>> 12) + b3;
        endfunction

        function longint ease(longint f);
            longint r, sq, lo, hi, mid, x1, y1, x2, y2;
            if (f <= 0) return 0;
            if (f >= ONE) return ONE;
            case (kind)
                aee_pkg::KIND_QUAD_IN:  return shr16(f * f);
                aee_pkg::KIND_QUAD_OUT: begin
                    r = ONE - f;
                    return ONE - shr16(r * r);
                end
                aee_pkg::KIND_SMOOTH: begin
                    sq = shr16(f * f);
                    return shr16(sq * (3 * ONE - 2 * f));
                end
                aee_pkg::KIND_BEZIER: begin
                    x1 = longint'($signed(controls[15:0]));
                    y1 = longint'($signed(controls[31:16]));
                    x2 = longint'($signed(controls[47:32]));
                    y2 = longint'($signed(controls[63:48]));
                    lo = 0;
                    hi = ONE;
                    for (int i = 0; i < 16; i++) begin
                        mid = (lo + hi) >>> 1;
                        if (curve(x1, x2, mid) < f) lo = mid;
                        else hi = mid;
                    end
                    return curve(y1, y2, (lo + hi) >>> 1);
                end
                default: return f;   // linear, and the unused codes
            endcase
        endfunction

        function longint lerp(longint frac);
            longint v;
            v = from_v + shr16((to_v - from_v) * frac);
            if (v > 64'sd2147483647) v = 64'sd2147483647;
            if (v < -64'sd2147483648) v = -64'sd2147483648;
            return v;
        endfunction

        // note an accepted input transfer
        function void note_sample(logic [47:0] el, logic signed [31:0] dl);
            t_sample_res     e;
            longint unsigned elapsed, act, leg, rem;
            longint          frac, value, eased, raw, fo;
            bit              rev, term;
            elapsed = 64'(el);
            act   = (elapsed > delay) ? elapsed - delay : 0;
            leg   = 0;
            frac  = 0;
            value = from_v;
            rev   = 0;
            term  = 0;
            if (elapsed >= delay) begin
                if (legs > 0 && elapsed >= delay + dur * legs) begin
                    term  = 1;
                    leg   = legs - 1;
                    rev   = rev_mode[0] && leg[0];
                    frac  = rev ? 0 : ONE;
                    value = rev ? from_v : to_v;
                end else if (dur == 0) begin
                    term  = 1;
                    frac  = ONE;
                    value = to_v;
                end else begin
                    rem   = act % dur;
                    raw   = longint'((rem << 16) / dur);
                    eased = ease(raw);
                    leg   = act / dur;
                    rev   = rev_mode[0] && leg[0];
                    frac  = rev ? ONE - eased : eased;
                    value = lerp(frac);
                end
            end
            fo = (frac < 0) ? 0 : ((frac > ONE) ? ONE : frac);
            e.active = act[47:0];
            e.leg    = leg[47:0];
            e.frac   = fo[16:0];
            e.value  = value[31:0];
            e.rev    = rev;
            e.term   = term;
            e.delta  = dl;
            pending_q.push_back(e);
        endfunction

        // compare one result transfer against the oldest expectation
        function void check_result(t_sample_res got);
            t_sample_res e;
            if (pending_q.size() == 0) begin
                $error("result transfer with nothing expected");
                errors++;
                return;
            end
            e = pending_q.pop_front();
            n_checked++;
            if (got.active !== e.active) begin
                $error("active_time: expected %0d, got %0d", e.active, got.active); errors++;
            end
            if (got.leg !== e.leg) begin
                $error("leg_index: expected %0d, got %0d", e.leg, got.leg); errors++;
            end
            if (got.frac !== e.frac) begin
                $error("fraction_out: expected %0d, got %0d", e.frac, got.frac); errors++;
            end
            if (got.value !== e.value) begin
                $error("value_out: expected %0d, got %0d", e.value, got.value); errors++;
            end
            if (got.rev !== e.rev) begin
                $error("reversed: expected %0b, got %0b", e.rev, got.rev); errors++;
            end
            if (got.term !== e.term) begin
                $error("terminal: expected %0b, got %0b", e.term, got.term); errors++;
            end
            if (got.delta !== e.delta) begin
                $error("delta_out: expected %0d, got %0d", e.delta, got.delta); errors++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // DUT hookup
    // ------------------------------------------------------------------------
    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [aee_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [aee_pkg::CFG_W-1:0]     i_cfg_data = '0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    logic [47:0]        i_elapsed_us = '0;
    logic signed [31:0] i_delta_us = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic [47:0]        o_active_time, o_leg_index;
    logic [16:0]        o_fraction_out;
    logic signed [31:0] o_value_out, o_delta_out;
    logic               o_reversed, o_terminal;

    animation_easing_evaluator dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_elapsed_us   (i_elapsed_us),
        .i_delta_us     (i_delta_us),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_active_time  (o_active_time),
        .o_leg_index    (o_leg_index),
        .o_fraction_out (o_fraction_out),
        .o_value_out    (o_value_out),
        .o_reversed     (o_reversed),
        .o_terminal     (o_terminal),
        .o_delta_out    (o_delta_out)
    );

    // 8 ns clock
    always #4 i_clk = ~i_clk;

    easing_scoreboard sb = new();
    longint           cycle_cnt = 0;
    int               n_sent = 0;
    int               burst_left = 0;

    // watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("[animation_easing_evaluator] ERROR");
            $finish;
        end
    end

    // Receiver back-pressure: the pattern steps periodically between
    // always ready, coin flip, mostly stalled and long stall runs.
    always @(posedge i_clk) begin
        case (cycle_cnt[9:8])
            2'd0: i_out_ready <= 1'b1;
            2'd1: i_out_ready <= $urandom_range(0, 1);
            2'd2: i_out_ready <= ($urandom_range(0, 3) == 0);
            default: i_out_ready <= (cycle_cnt[5:3] != 3'd0);
        endcase
    end

    // result monitor: sample the pre-edge values at the transfer edge
    always @(posedge i_clk) begin
        t_sample_res got;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got.active = o_active_time;
            got.leg    = o_leg_index;
            got.frac   = o_fraction_out;
            got.value  = o_value_out;
            got.rev    = o_reversed;
            got.term   = o_terminal;
            got.delta  = o_delta_out;
            sb.check_result(got);
        end
    end

    // ------------------------------------------------------------------------
    // Driver tasks (all entered just after a rising edge)
    // ------------------------------------------------------------------------
    // write enable stays high across a run of writes; cfg_all drops it
    task automatic cfg_write(aee_pkg::t_reg_idx idx, logic [63:0] d);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= d;
        sb.set_reg(idx, d);
        @(posedge i_clk);
    endtask

    task automatic cfg_all(logic [31:0] delay, logic [31:0] dur, logic [15:0] legs,
                           logic [2:0] kind, logic rev, logic [31:0] from_v,
                           logic [31:0] to_v, logic [63:0] ctl);
        cfg_write(aee_pkg::REG_DELAY, 64'(delay));
        cfg_write(aee_pkg::REG_DURATION, 64'(dur));
        cfg_write(aee_pkg::REG_LEGS, 64'(legs));
        cfg_write(aee_pkg::REG_KIND, 64'(kind));
        cfg_write(aee_pkg::REG_REVERSE, 64'(rev));
        cfg_write(aee_pkg::REG_FROM, 64'(from_v));
        cfg_write(aee_pkg::REG_TO, 64'(to_v));
        cfg_write(aee_pkg::REG_CONTROLS, ctl);
        i_cfg_we <= 1'b0;
    endtask

    // One sample transfer. Bursts keep valid high across items; between
    // bursts valid drops for a random gap.
    task automatic send_sample(logic [47:0] el, logic signed [31:0] dl);
        i_in_valid   <= 1'b1;
        i_elapsed_us <= el;
        i_delta_us   <= dl;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_sample(el, dl);
        n_sent++;
        if (burst_left == 0) begin
            burst_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 40);
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end else begin
            burst_left--;
        end
    endtask

    // let every expected result arrive; leaves valid low
    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.pending_q.size() != 0) @(posedge i_clk);
        @(posedge i_clk);
    endtask

    function automatic longint unsigned rnd64();
        return {$urandom, $urandom};
    endfunction

    // Elapsed time aimed at the interesting region of the current registers:
    // inside the delay, on its edge, across the legs, at the end, or anywhere.
    function automatic logic [47:0] pick_elapsed();
        longint unsigned span, base;
        base = sb.delay;
        span = sb.dur * ((sb.legs != 0) ? sb.legs : 5) + 2;
        case ($urandom_range(0, 15))
            0:       return 48'(rnd64());
            1:       return 48'((base > 0) ? base - 1 : 0);
            2:       return 48'(base);
            3:       return 48'(base + sb.dur * sb.legs);
            4:       return 48'((base > 0) ? rnd64() % base : 0);
            5:       return '1;
            default: return 48'(base + rnd64() % span);
        endcase
    endfunction

    function automatic logic [63:0] pick_controls();
        logic [15:0] x1, y1, x2, y2;
        if ($urandom_range(0, 3) == 0) return rnd64();   // anything goes
        x1 = 16'($urandom_range(0, 4096));
        x2 = 16'($urandom_range(0, 4096));
        y1 = 16'($urandom_range(0, 8192)) - 16'd2048;      // mild overshoot
        y2 = 16'($urandom_range(0, 8192)) - 16'd2048;
        return {y2, x2, y1, x1};
    endfunction

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        logic [31:0] r_delay, r_dur, r_from, r_to;
        logic [15:0] r_legs;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset registers: zero duration, endless legs -> always terminal
        send_sample(48'd0, 32'sh8000_0000);
        send_sample('1, 32'sh7fff_ffff);
        drain();

        // directed: one short finite reversing animation per easing code,
        // sampled in leg 0 (code 7: leg 1), in backward leg 1 and past the end
        for (int k = 0; k < 8; k++) begin
            cfg_all(32'd100, 32'd1000, 16'd3, 3'(k), 1'b1, 32'hfff0_0000,
                    32'h0010_0000, 64'h0800_0000_1000_0400);
            send_sample(48'd100 + 48'(250 * (k + 1) / 2), 32'(k));
            send_sample(48'd1100 + 48'(117 * k), -32'sd5);
            send_sample(48'd3100 + 48'(k), 32'sd0);
            drain();
        end

        // random phases; the drain at each phase end is also the
        // "sender waits for everything" pressure point
        for (int ph = 0; ph < 14; ph++) begin
            case (ph)
                0: begin                   // widest registers
                    r_delay = '1; r_dur = '1; r_legs = '1;
                end
                1: begin                   // narrowest legs, endless
                    r_delay = 32'd0; r_dur = 32'd1; r_legs = 16'd0;
                end
                2: begin                   // zero duration, finite legs
                    r_delay = $urandom_range(0, 1000); r_dur = 32'd0; r_legs = 16'd4;
                end
                default: begin
                    r_delay = ($urandom_range(0, 4) == 0) ? $urandom
                                                            : $urandom_range(0, 5000);
                    r_dur   = ($urandom_range(0, 5) == 0) ? $urandom
                                                            : $urandom_range(1, 70000);
                    r_legs  = ($urandom_range(0, 2) == 0) ? 16'd0
                                                            : 16'($urandom_range(1, 9));
                end
            endcase
            if (ph < 2) begin           // saturating value range
                r_from = (ph == 0) ? 32'h8000_0000 : 32'h7fff_ffff;
                r_to   = (ph == 0) ? 32'h7fff_ffff : 32'h8000_0000;
            end else begin
                r_from = $urandom;
                r_to   = $urandom;
            end
            cfg_all(r_delay, r_dur, r_legs,
                    3'((ph < 5) ? aee_pkg::KIND_BEZIER : $urandom_range(0, 7)),
                    1'($urandom), r_from, r_to, pick_controls());
            for (int n = 0; n < 125; n++)
                send_sample(pick_elapsed(), $urandom);
            drain();
        end

        // final quiet period in case the block emits something unexpected
        repeat (PIPE_DRAIN) @(posedge i_clk);

        $display("sent %0d samples, checked %0d results over 23 register settings",
                 n_sent, sb.n_checked);
        $display("all easing codes, both playback modes, delay/end/zero-duration cases");
        if (sb.errors == 0 && sb.pending_q.size() == 0) begin
            $display("[animation_easing_evaluator] OK");
        end else begin
            $display("[animation_easing_evaluator] ERROR");
        end
        $finish;
    end

endmodule
